// ===== hw/rtl/wlc_pkg.sv =====
// Shared constants and types for the weighted LRU cache core.
package wlc_pkg;

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 20;
    localparam int COUNT_W  = 5;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_SET     = 2'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [PADDR_W-1:0] ADDR_MAX_ENTRIES  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_MAX_WEIGHT   = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_FLOOR        = 4'h8;

    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

// ===== hw/rtl/weighted_lru_cache_core.sv =====
// Weighted LRU key-value cache core with eviction by count and weight limits.
// Input channel (in_valid/in_ready) carries one request beat: operation, key,
// data_in, weight_in. Output channel (out_valid/out_ready) returns one beat per
// request, or one beat per evicted key for a set; last marks the final beat.
// Entries live in one synchronous memory (registered read port); the recency
// order is a list of slot indices, oldest first.
// One request is in flight at a time. The lookup walks the order list, one
// entry per ST_RD/ST_CMP pair, until a hit or the last entry; then ST_ACT acts.
// A set then checks the limits (ST_EVCHK), chooses each evicted entry (ST_EVD),
// reports each one (ST_EMRD, ST_EMIT) and then inserts the new entry (ST_INS).
// A waiting output beat does not block acceptance of the next request; the
// core only stalls while it must present a new beat, the previous beat is
// still waiting and out_ready is low.
// Reset empties the cache (all slots invalid, count and weight zero) and
// clears the limit registers; there is no clearing pass.
// Limits are written over the APB port at 0x0 (max_entries), 0x4
// (max_total_weight) and 0x8 (weight_floor_entries); the user must write them
// only while the core is idle, as the core itself does not enforce this.
module weighted_lru_cache_core #(
    parameter int CAPACITY  = 16,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wlc_pkg::PADDR_W-1:0]   paddr,
    input  logic [wlc_pkg::PDATA_W-1:0]   pwdata,
    output logic [wlc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wlc_pkg::OP_W-1:0]      operation,
    input  logic [wlc_pkg::FIELD_W-1:0]   key,
    input  logic [wlc_pkg::FIELD_W-1:0]   data_in,
    input  logic [wlc_pkg::WEIGHT_W-1:0]  weight_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [wlc_pkg::FIELD_W-1:0]   data_out,
    output logic                          evicted_valid,
    output logic [wlc_pkg::FIELD_W-1:0]   evicted_key,
    output logic                          status,
    output logic [wlc_pkg::COUNT_W-1:0]   entry_count,
    output logic [wlc_pkg::TOTAL_W-1:0]   weight_total,
    output logic                          last
);
    import wlc_pkg::*;

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int EW  = KEY_BITS + DATA_BITS + WEIGHT_W;
    localparam int KW  = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int DW  = (DATA_BITS < FIELD_W) ? DATA_BITS : FIELD_W;
    localparam int XW  = 8;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_CMP   = 4'd2;
    localparam logic [3:0] ST_ACT   = 4'd3;
    localparam logic [3:0] ST_EVCHK = 4'd4;
    localparam logic [3:0] ST_EVD   = 4'd5;
    localparam logic [3:0] ST_INS   = 4'd6;
    localparam logic [3:0] ST_EMRD  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [EW-1:0]        mem [CAPACITY];
    logic [EW-1:0]        rdata_reg;
    logic [IW-1:0]        raddr;
    logic                 we;
    logic [IW-1:0]        waddr;
    logic [EW-1:0]        wdata;

    logic [3:0]           state_reg, state_next;
    logic [IW-1:0]        ord_reg [CAPACITY];
    logic [IW-1:0]        ord_next [CAPACITY];
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    logic [CW-1:0]        n_reg, n_next;
    total_t               wt_reg, wt_next;

    logic [4:0]           max_entries_reg;
    total_t               max_weight_reg;
    logic [4:0]           floor_reg;

    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    weight_t              w_reg, w_next;
    logic [IW-1:0]        p_reg, p_next;
    logic                 hit_reg, hit_next;
    logic [DATA_BITS-1:0] hdata_reg, hdata_next;
    weight_t              hw_reg, hw_next;
    logic [CW-1:0]        ev_cnt_reg, ev_cnt_next;

    logic                 out_valid_reg;
    logic                 o_hit_reg, o_ev_reg, o_status_reg, o_last_reg;
    logic [FIELD_W-1:0]   o_data_reg, o_key_reg;
    logic [COUNT_W-1:0]   o_count_reg;
    total_t               o_wt_reg;

    logic                 emit;
    logic                 e_hit, e_ev, e_status, e_last;
    logic [DATA_BITS-1:0] e_data;
    logic [KEY_BITS-1:0]  e_key;
    logic [CW-1:0]        e_count;
    total_t               e_wt;
    logic                 out_free;

    logic [KEY_BITS-1:0]  key_ext;
    logic [DATA_BITS-1:0] data_ext;
    logic [KEY_BITS-1:0]  rd_key;
    logic [DATA_BITS-1:0] rd_data;
    weight_t              rd_w;
    logic [IW-1:0]        free_slot;
    logic [IW-1:0]        hslot;
    logic                 more_now;
    logic [CW-1:0]        n_ev;
    total_t               wt_ev;

    function automatic logic need_evict(input logic [CW-1:0] n, input total_t wt,
                                        input weight_t w, input logic [4:0] me,
                                        input total_t mw, input logic [4:0] fl);
        logic [XW-1:0] nx;
        logic [TOTAL_W:0] sum;
        logic r;
        nx  = XW'(n);
        sum = {1'b0, wt} + (TOTAL_W+1)'(w);
        r   = (nx >= XW'(CAPACITY));
        if (me != 5'd0 && nx >= XW'(me))
            r = 1'b1;
        if (mw != '0 && sum > {1'b0, mw} && nx > XW'(fl))
            r = 1'b1;
        return r;
    endfunction

    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr)
            ADDR_MAX_ENTRIES: prdata = PDATA_W'(max_entries_reg);
            ADDR_MAX_WEIGHT:  prdata = PDATA_W'(max_weight_reg);
            ADDR_FLOOR:       prdata = PDATA_W'(floor_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= '0;
            max_weight_reg  <= '0;
            floor_reg       <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_MAX_ENTRIES: max_entries_reg <= pwdata[4:0];
                ADDR_MAX_WEIGHT:  max_weight_reg  <= pwdata[TOTAL_W-1:0];
                ADDR_FLOOR:       floor_reg       <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        key_ext  = '0;
        data_ext = '0;
        for (int i = 0; i < KW; i++)
            key_ext[i] = key[i];
        for (int i = 0; i < DW; i++)
            data_ext[i] = data_in[i];
    end

    assign rd_key  = rdata_reg[EW-1 -: KEY_BITS];
    assign rd_data = rdata_reg[WEIGHT_W +: DATA_BITS];
    assign rd_w    = rdata_reg[WEIGHT_W-1:0];
    assign hslot   = ord_reg[p_reg];
    assign raddr   = (state_reg == ST_RD || state_reg == ST_EMRD || state_reg == ST_EMIT) ?
                     ord_reg[p_reg] : ord_reg[0];
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (!valid_reg[i])
                free_slot = IW'(i);
    end

    assign more_now = need_evict(n_reg, wt_reg, w_reg, max_entries_reg,
                                 max_weight_reg, floor_reg);
    assign n_ev     = n_reg - CW'(1);
    assign wt_ev    = wt_reg - TOTAL_W'(rd_w);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        ord_next    = ord_reg;
        valid_next  = valid_reg;
        n_next      = n_reg;
        wt_next     = wt_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        data_next   = data_reg;
        w_next      = w_reg;
        p_next      = p_reg;
        hit_next    = hit_reg;
        hdata_next  = hdata_reg;
        hw_next     = hw_reg;
        ev_cnt_next = ev_cnt_reg;
        we          = 1'b0;
        waddr       = free_slot;
        wdata       = {key_reg, data_reg, w_reg};
        emit        = 1'b0;
        e_hit       = 1'b0;
        e_ev        = 1'b0;
        e_status    = 1'b0;
        e_last      = 1'b1;
        e_key       = '0;
        e_data      = '0;
        e_count     = n_reg;
        e_wt        = wt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = operation;
                    key_next    = key_ext;
                    data_next   = data_ext;
                    w_next      = weight_in;
                    p_next      = '0;
                    hit_next    = 1'b0;
                    ev_cnt_next = '0;
                    state_next  = (n_reg == '0) ? ST_ACT : ST_RD;
                end
            end
            ST_RD:
                state_next = ST_CMP;
            ST_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    hit_next   = 1'b1;
                    hdata_next = rd_data;
                    hw_next    = rd_w;
                    state_next = ST_ACT;
                end
                else if (CW'(p_reg) == n_reg - CW'(1))
                    state_next = ST_ACT;
                else
                begin
                    p_next     = p_reg + IW'(1);
                    state_next = ST_RD;
                end
            end
            ST_ACT:
            begin
                if (op_reg == OP_SET)
                begin
                    if (hit_reg)
                    begin
                        for (int i = 0; i < CAPACITY - 1; i++)
                            if (i >= int'(p_reg))
                                ord_next[i] = ord_reg[i+1];
                        valid_next[hslot] = 1'b0;
                        n_next  = n_reg - CW'(1);
                        wt_next = wt_reg - TOTAL_W'(hw_reg);
                    end
                    state_next = ST_EVCHK;
                end
                else if (out_free)
                begin
                    emit  = 1'b1;
                    e_hit = hit_reg && (op_reg == OP_GET || op_reg == OP_REPLACE);
                    if (op_reg == OP_GET && hit_reg)
                        e_data = hdata_reg;
                    if (op_reg == OP_REPLACE)
                    begin
                        e_status = !hit_reg;
                        if (hit_reg)
                        begin
                            we    = 1'b1;
                            waddr = hslot;
                            wdata = {key_reg, data_reg, hw_reg};
                        end
                    end
                    if (hit_reg && (op_reg == OP_GET || op_reg == OP_REPLACE))
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (i >= int'(p_reg) && i < int'(n_reg) - 1)
                                ord_next[i] = ord_reg[(i + 1) % CAPACITY];
                            if (i == int'(n_reg) - 1)
                                ord_next[i] = hslot;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EVCHK:
            begin
                p_next = IW'(CW'(CAPACITY) - ev_cnt_reg);
                if (more_now && n_reg != '0)
                    state_next = ST_EVD;
                else if (ev_cnt_reg != '0)
                    state_next = ST_EMRD;
                else
                    state_next = ST_INS;
            end
            ST_EVD:
            begin
                // rotate so evicted slots collect at the tail, oldest first
                for (int i = 0; i < CAPACITY; i++)
                    ord_next[i] = ord_reg[(i + 1) % CAPACITY];
                valid_next[ord_reg[0]] = 1'b0;
                n_next      = n_ev;
                wt_next     = wt_ev;
                ev_cnt_next = ev_cnt_reg + CW'(1);
                state_next  = ST_EVCHK;
            end
            ST_EMRD:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    e_hit   = hit_reg;
                    e_ev    = 1'b1;
                    e_key   = rd_key;
                    e_count = n_reg + CW'(1);
                    e_wt    = wt_reg + TOTAL_W'(w_reg);
                    e_last  = (p_reg == IW'(CAPACITY - 1));
                    if (p_reg == IW'(CAPACITY - 1))
                        state_next = ST_INS;
                    else
                    begin
                        p_next     = p_reg + IW'(1);
                        state_next = ST_EMRD;
                    end
                end
            end
            ST_INS:
            begin
                if (ev_cnt_reg != '0 || out_free)
                begin
                    if (ev_cnt_reg == '0)
                    begin
                        emit    = 1'b1;
                        e_hit   = hit_reg;
                        e_count = n_reg + CW'(1);
                        e_wt    = wt_reg + TOTAL_W'(w_reg);
                    end
                    we    = 1'b1;
                    waddr = free_slot;
                    valid_next[free_slot] = 1'b1;
                    for (int i = 0; i < CAPACITY; i++)
                        if (i == int'(n_reg))
                            ord_next[i] = free_slot;
                    n_next     = n_reg + CW'(1);
                    wt_next    = wt_reg + TOTAL_W'(w_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            n_reg         <= '0;
            wt_reg        <= '0;
            out_valid_reg <= 1'b0;
            ev_cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            n_reg      <= n_next;
            wt_reg     <= wt_next;
            ev_cnt_reg <= ev_cnt_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg   <= ord_next;
        op_reg    <= op_next;
        key_reg   <= key_next;
        data_reg  <= data_next;
        w_reg     <= w_next;
        p_reg     <= p_next;
        hit_reg   <= hit_next;
        hdata_reg <= hdata_next;
        hw_reg    <= hw_next;
        if (emit)
        begin
            o_hit_reg    <= e_hit;
            o_ev_reg     <= e_ev;
            o_status_reg <= e_status;
            o_last_reg   <= e_last;
            o_count_reg  <= COUNT_W'(e_count);
            o_wt_reg     <= e_wt;
            o_data_reg   <= FIELD_W'(e_data);
            o_key_reg    <= FIELD_W'(e_key);
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = o_hit_reg;
    assign data_out      = o_data_reg;
    assign evicted_valid = o_ev_reg;
    assign evicted_key   = o_key_reg;
    assign status        = o_status_reg;
    assign entry_count   = o_count_reg;
    assign weight_total  = o_wt_reg;
    assign last          = o_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(n_reg) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> CW'($countones(valid_reg)) == n_reg)
        else $error("valid bits disagree with entry count");

    a_empty_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && n_reg == '0) |-> wt_reg == '0)
        else $error("weight left in empty cache");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result beat overwritten");

endmodule
